// ===== design/stall_reversing_sweep_sampler_unit_defines.svh =====
// Assertion macros shared by the sweep sampler RTL.
`ifndef STALL_REVERSING_SWEEP_SAMPLER_UNIT_DEFINES_SVH
`define STALL_REVERSING_SWEEP_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SRSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/srss_pkg.sv =====
// Package: widths, register indexes and the result type of the sweep sampler.
`timescale 1ns / 1ps
package srss_pkg;

  localparam int ANGLE_WIDTH = 24;
  localparam int STEP_WIDTH  = 16;
  localparam int DIST_WIDTH  = 16;
  localparam int SPEED_WIDTH = 8;
  localparam int TICKS_WIDTH = 16;
  localparam int DRIVE_WIDTH = SPEED_WIDTH + 1;
  localparam int CFG_WIDTH   = (ANGLE_WIDTH > TICKS_WIDTH) ? ANGLE_WIDTH : TICKS_WIDTH;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_DRIVE_SPEED = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_STALL_TICKS = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_STEP  = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_STOP_ANGLE  = 2'd3;

  localparam logic [SPEED_WIDTH-1:0]   RST_DRIVE_SPEED = SPEED_WIDTH'(100);
  localparam logic [TICKS_WIDTH-1:0]   RST_STALL_TICKS = TICKS_WIDTH'(5);
  localparam logic [ANGLE_WIDTH-2:0]   RST_ANGLE_STEP  = (ANGLE_WIDTH-1)'(65536);
  localparam logic [TICKS_WIDTH-1:0]   IDLE_MAX        = '1;

  typedef struct packed {
    logic signed [DRIVE_WIDTH-1:0] motor_drive;
    logic                          zero_encoder;
    logic                          sample_valid;
    logic signed [ANGLE_WIDTH-1:0] orientation;
    logic [DIST_WIDTH-1:0]         sample_distance;
    logic                          sweep_end;
  } result_t;

endpackage

// ===== design/stall_reversing_sweep_sampler_unit.sv =====
// Top level of the stall-reversing sweep sampler.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  run, position, step_count, distance
//   out_     output     out_valid/out_stall motor_drive, zero_encoder, sample_valid,
//                                          orientation, sample_distance, sweep_end
//   cfg_     input      cfg_we             cfg_index, cfg_data
//
// One tick is taken per cycle while in_stall is low; its result goes to the output
// register, or to the skid register when that is full and stalled. Sweep state
// updates in compare and subtract logic, so back-to-back ticks need no bubble. A
// skid register holds one further result while out_stall is high; in_stall rises only when it is full.
// Reset (rst_n low, synchronous) restores register defaults and clears all sweep
// state and both result slots.
`timescale 1ns / 1ps
`include "stall_reversing_sweep_sampler_unit_defines.svh"
module stall_reversing_sweep_sampler_unit
  import srss_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_run,
  input  logic signed [ANGLE_WIDTH-1:0] in_position,
  input  logic [STEP_WIDTH-1:0]         in_step_count,
  input  logic [DIST_WIDTH-1:0]         in_distance,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DRIVE_WIDTH-1:0] out_motor_drive,
  output logic                          out_zero_encoder,
  output logic                          out_sample_valid,
  output logic signed [ANGLE_WIDTH-1:0] out_orientation,
  output logic [DIST_WIDTH-1:0]         out_sample_distance,
  output logic                          out_sweep_end,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [CFG_WIDTH-1:0]          cfg_data
);

  localparam logic signed [ANGLE_WIDTH:0] ORIENT_MAX =
    (ANGLE_WIDTH+1)'((1 << (ANGLE_WIDTH-1)) - 1);
  localparam logic signed [ANGLE_WIDTH:0] ORIENT_MIN = -ORIENT_MAX - (ANGLE_WIDTH+1)'(1);

  // Configuration registers
  logic [SPEED_WIDTH-1:0]         drive_speed_r;
  logic [TICKS_WIDTH-1:0]         stall_ticks_r;
  logic [ANGLE_WIDTH-2:0]         angle_step_r;
  logic signed [ANGLE_WIDTH-1:0]  orient_base_r;

  // Sweep state
  logic                           drive_positive_r, drive_positive_nxt;
  logic                           sampling_on_r, sampling_on_nxt;
  logic [STEP_WIDTH-1:0]          previous_step_r, previous_step_nxt;
  logic                           step_seen_r, step_seen_nxt;
  logic [TICKS_WIDTH-1:0]         idle_count_r, idle_count_nxt;
  logic signed [ANGLE_WIDTH-1:0]  last_pos_r, last_pos_nxt;
  logic                           sample_seen_r, sample_seen_nxt;
  logic                           has_samples_r, has_samples_nxt;

  // Result slots
  result_t                        res_nxt;
  result_t                        main_r, main_nxt;
  result_t                        skid_r, skid_nxt;
  logic                           main_valid_r, main_valid_nxt;
  logic                           skid_valid_r, skid_valid_nxt;

  logic                           in_acc;
  logic                           out_take;
  logic                           moved;
  logic                           stuck;
  logic                           sampling_now;
  logic                           take_sample;
  logic signed [ANGLE_WIDTH:0]    pos_diff;
  logic [ANGLE_WIDTH:0]           pos_mag;
  logic signed [ANGLE_WIDTH:0]    orient_full;
  logic signed [ANGLE_WIDTH-1:0]  orient_sat;
  logic signed [DRIVE_WIDTH-1:0]  drive_mag;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid & ~skid_valid_r;
  assign out_take = main_valid_r & ~out_stall;

  // Tick evaluation
  always_comb begin
    drive_positive_nxt = drive_positive_r;
    sampling_on_nxt    = sampling_on_r;
    previous_step_nxt  = previous_step_r;
    step_seen_nxt      = step_seen_r;
    idle_count_nxt     = idle_count_r;
    last_pos_nxt       = last_pos_r;
    sample_seen_nxt    = sample_seen_r;
    has_samples_nxt    = has_samples_r;
    res_nxt            = '0;

    moved = ~step_seen_r | (in_step_count != previous_step_r);
    if (moved) begin
      step_seen_nxt     = 1'b1;
      previous_step_nxt = in_step_count;
      idle_count_nxt    = '0;
    end else if (idle_count_r != IDLE_MAX) begin
      idle_count_nxt    = idle_count_r + 1'b1;
    end
    stuck = idle_count_nxt > stall_ticks_r;

    sampling_now = sampling_on_r;
    if (stuck && !drive_positive_r) begin
      drive_positive_nxt   = 1'b1;
      sampling_on_nxt      = 1'b1;
      sampling_now         = 1'b1;
      res_nxt.zero_encoder = 1'b1;
    end else if (stuck && drive_positive_r) begin
      drive_positive_nxt   = 1'b0;
      res_nxt.sweep_end    = has_samples_r;
      has_samples_nxt      = 1'b0;
      sampling_on_nxt      = 1'b0;
      sampling_now         = 1'b0;
    end

    pos_diff = {last_pos_r[ANGLE_WIDTH-1], last_pos_r} - {in_position[ANGLE_WIDTH-1], in_position};
    pos_mag  = pos_diff[ANGLE_WIDTH] ? (ANGLE_WIDTH+1)'(-pos_diff) : pos_diff;
    orient_full = {in_position[ANGLE_WIDTH-1], in_position}
                - {orient_base_r[ANGLE_WIDTH-1], orient_base_r};
    if (orient_full > ORIENT_MAX) begin
      orient_sat = ORIENT_MAX[ANGLE_WIDTH-1:0];
    end else if (orient_full < ORIENT_MIN) begin
      orient_sat = ORIENT_MIN[ANGLE_WIDTH-1:0];
    end else begin
      orient_sat = orient_full[ANGLE_WIDTH-1:0];
    end

    take_sample = sampling_now & (~sample_seen_r | (pos_mag > {2'b00, angle_step_r}));
    if (take_sample) begin
      sample_seen_nxt         = 1'b1;
      last_pos_nxt            = in_position;
      has_samples_nxt         = 1'b1;
      res_nxt.sample_valid    = 1'b1;
      res_nxt.orientation     = orient_sat;
      res_nxt.sample_distance = in_distance;
    end

    drive_mag = {1'b0, drive_speed_r};
    res_nxt.motor_drive = drive_positive_nxt ? drive_mag : -drive_mag;

    // A stopped tick clears the sweep and reports an all-zero result.
    if (!in_run) begin
      drive_positive_nxt = 1'b0;
      sampling_on_nxt    = 1'b0;
      previous_step_nxt  = '0;
      step_seen_nxt      = 1'b0;
      idle_count_nxt     = '0;
      last_pos_nxt       = '0;
      sample_seen_nxt    = 1'b0;
      has_samples_nxt    = 1'b0;
      res_nxt            = '0;
    end
  end

  // Output register with one skid slot
  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (in_acc && (!main_valid_r || out_take)) begin
      main_nxt       = res_nxt;
      main_valid_nxt = 1'b1;
    end else if (in_acc) begin
      skid_nxt       = res_nxt;
      skid_valid_nxt = 1'b1;
    end else if (out_take) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_speed_r    <= RST_DRIVE_SPEED;
      stall_ticks_r    <= RST_STALL_TICKS;
      angle_step_r     <= RST_ANGLE_STEP;
      orient_base_r    <= '0;
      drive_positive_r <= 1'b0;
      sampling_on_r    <= 1'b0;
      previous_step_r  <= '0;
      step_seen_r      <= 1'b0;
      idle_count_r     <= '0;
      last_pos_r       <= '0;
      sample_seen_r    <= 1'b0;
      has_samples_r    <= 1'b0;
      main_valid_r     <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DRIVE_SPEED: drive_speed_r <= cfg_data[SPEED_WIDTH-1:0];
          REG_STALL_TICKS: stall_ticks_r <= cfg_data[TICKS_WIDTH-1:0];
          REG_ANGLE_STEP:  angle_step_r  <= cfg_data[ANGLE_WIDTH-2:0];
          REG_STOP_ANGLE:  orient_base_r <= cfg_data[ANGLE_WIDTH-1:0];
        endcase
      end
      if (in_acc) begin
        drive_positive_r <= drive_positive_nxt;
        sampling_on_r    <= sampling_on_nxt;
        previous_step_r  <= previous_step_nxt;
        step_seen_r      <= step_seen_nxt;
        idle_count_r     <= idle_count_nxt;
        last_pos_r       <= last_pos_nxt;
        sample_seen_r    <= sample_seen_nxt;
        has_samples_r    <= has_samples_nxt;
      end
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid           = main_valid_r;
  assign out_motor_drive     = main_r.motor_drive;
  assign out_zero_encoder    = main_r.zero_encoder;
  assign out_sample_valid    = main_r.sample_valid;
  assign out_orientation     = main_r.orientation;
  assign out_sample_distance = main_r.sample_distance;
  assign out_sweep_end       = main_r.sweep_end;

  `SRSS_ASSERT_IMPL(a_skid_behind_main, clk, rst_n, skid_valid_r, main_valid_r,
    "skid slot holds an item while the output register is empty")
  `SRSS_ASSERT_IMPL(a_no_zero_and_end, clk, rst_n, main_valid_r,
    !(main_r.zero_encoder && main_r.sweep_end),
    "one tick both zeroed the encoder and ended a sweep")
  `SRSS_ASSERT_IMPL(a_zero_drive_pos, clk, rst_n, main_valid_r && main_r.zero_encoder,
    !main_r.motor_drive[DRIVE_WIDTH-1], "encoder zeroed while drive is negative")
  `SRSS_ASSERT_IMPL(a_empty_sample, clk, rst_n, main_valid_r && !main_r.sample_valid,
    main_r.orientation == '0 && main_r.sample_distance == '0,
    "sample fields not cleared without a sample")
  `SRSS_ASSERT_NEXT(a_accept_shows, clk, rst_n, in_acc && !main_valid_r, main_valid_r,
    "accepted item did not reach the output register")

endmodule

// ===== bench/tb_stall_reversing_sweep_sampler_unit.sv =====
// Testbench for the stall-reversing sweep sampler: directed and random ticks against a predictor.
`timescale 1ns / 1ps
module tb_stall_reversing_sweep_sampler_unit
  import srss_pkg::*;
;

  class sweep_scoreboard;
    logic [SPEED_WIDTH-1:0]        drive_speed;
    logic [TICKS_WIDTH-1:0]        stall_ticks;
    logic [ANGLE_WIDTH-2:0]        angle_step;
    logic signed [ANGLE_WIDTH-1:0] orient_base;

    bit                            drive_positive;
    bit                            sampling_on;
    logic [STEP_WIDTH-1:0]         previous_step;
    bit                            step_seen;
    logic [TICKS_WIDTH-1:0]        idle_count;
    logic signed [ANGLE_WIDTH-1:0] last_sample_pos;
    bit                            sample_seen;
    bit                            sweep_has_samples;

    result_t                       expected_results[$];
    int                            errors;

    function new();
      drive_speed = RST_DRIVE_SPEED;
      stall_ticks = RST_STALL_TICKS;
      angle_step  = RST_ANGLE_STEP;
      orient_base = '0;
      errors      = 0;
      clear_sweep();
    endfunction

    function void clear_sweep();
      drive_positive    = 1'b0;
      sampling_on       = 1'b0;
      previous_step     = '0;
      step_seen         = 1'b0;
      idle_count        = '0;
      last_sample_pos   = '0;
      sample_seen       = 1'b0;
      sweep_has_samples = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] index, logic [CFG_WIDTH-1:0] data);
      case (index)
        REG_DRIVE_SPEED: drive_speed = data[SPEED_WIDTH-1:0];
        REG_STALL_TICKS: stall_ticks = data[TICKS_WIDTH-1:0];
        REG_ANGLE_STEP:  angle_step  = data[ANGLE_WIDTH-2:0];
        REG_STOP_ANGLE:  orient_base = data[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Works out the result of one accepted tick and queues it.
    function void note_tick(logic run, logic signed [ANGLE_WIDTH-1:0] pos,
                            logic [STEP_WIDTH-1:0] step, logic [DIST_WIDTH-1:0] reading);
      result_t                     r;
      bit                          stuck;
      logic signed [ANGLE_WIDTH:0] gap;
      logic [ANGLE_WIDTH:0]        gap_mag;
      logic signed [ANGLE_WIDTH:0] orient_wide;
      r = '0;
      if (!run) begin
        clear_sweep();
        expected_results = {expected_results, r};
        return;
      end
      if (!step_seen || step != previous_step) begin
        step_seen     = 1'b1;
        previous_step = step;
        idle_count    = '0;
      end else if (idle_count != IDLE_MAX) begin
        idle_count++;
      end
      stuck = idle_count > stall_ticks;

      if (stuck && !drive_positive) begin
        drive_positive  = 1'b1;
        sampling_on     = 1'b1;
        r.zero_encoder  = 1'b1;
      end else if (stuck) begin
        drive_positive    = 1'b0;
        r.sweep_end       = sweep_has_samples;
        sweep_has_samples = 1'b0;
        sampling_on       = 1'b0;
      end

      // Stall handling comes first, so the tick that enables sampling may sample.
      if (sampling_on) begin
        gap     = last_sample_pos - pos;
        gap_mag = gap[ANGLE_WIDTH] ? -gap : gap;
        if (!sample_seen || gap_mag > angle_step) begin
          orient_wide = pos - orient_base;
          if (orient_wide[ANGLE_WIDTH] != orient_wide[ANGLE_WIDTH-1])
            r.orientation = orient_wide[ANGLE_WIDTH] ? {1'b1, {(ANGLE_WIDTH-1){1'b0}}}
                                                     : {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
          else
            r.orientation = orient_wide[ANGLE_WIDTH-1:0];
          sample_seen       = 1'b1;
          last_sample_pos   = pos;
          sweep_has_samples = 1'b1;
          r.sample_valid    = 1'b1;
          r.sample_distance = reading;
        end
      end

      r.motor_drive = drive_positive ? $signed({1'b0, drive_speed})
                                     : -$signed({1'b0, drive_speed});
      expected_results = {expected_results, r};
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.motor_drive !== want.motor_drive)
        report("motor_drive", want.motor_drive, got.motor_drive);
      if (got.zero_encoder !== want.zero_encoder)
        report("zero_encoder", want.zero_encoder, got.zero_encoder);
      if (got.sample_valid !== want.sample_valid)
        report("sample_valid", want.sample_valid, got.sample_valid);
      if (got.orientation !== want.orientation)
        report("orientation", want.orientation, got.orientation);
      if (got.sample_distance !== want.sample_distance)
        report("sample_distance", want.sample_distance, got.sample_distance);
      if (got.sweep_end !== want.sweep_end)
        report("sweep_end", want.sweep_end, got.sweep_end);
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_run;
  logic signed [ANGLE_WIDTH-1:0] in_position;
  logic [STEP_WIDTH-1:0]         in_step_count;
  logic [DIST_WIDTH-1:0]         in_distance;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [DRIVE_WIDTH-1:0] out_motor_drive;
  logic                          out_zero_encoder;
  logic                          out_sample_valid;
  logic signed [ANGLE_WIDTH-1:0] out_orientation;
  logic [DIST_WIDTH-1:0]         out_sample_distance;
  logic                          out_sweep_end;
  logic                          cfg_we;
  logic [CFG_IDX_WIDTH-1:0]      cfg_index;
  logic [CFG_WIDTH-1:0]          cfg_data;

  sweep_scoreboard tracker = new();

  int                            send_idle_pct;
  int                            recv_stall_pct;
  bit                            hold_req;
  int unsigned                   cur_stall;
  int unsigned                   cur_astep;
  logic signed [ANGLE_WIDTH-1:0] cur_pos;
  logic [STEP_WIDTH-1:0]         cur_step;

  stall_reversing_sweep_sampler_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_run              (in_run),
    .in_position         (in_position),
    .in_step_count       (in_step_count),
    .in_distance         (in_distance),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_motor_drive     (out_motor_drive),
    .out_zero_encoder    (out_zero_encoder),
    .out_sample_valid    (out_sample_valid),
    .out_orientation     (out_orientation),
    .out_sample_distance (out_sample_distance),
    .out_sweep_end       (out_sweep_end),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Values are sampled at the edge, before any update scheduled for that edge lands.
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n) begin
      if (cfg_we)
        tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        tracker.note_tick(in_run, in_position, in_step_count, in_distance);
      if (out_valid && !out_stall) begin
        got.motor_drive     = out_motor_drive;
        got.zero_encoder    = out_zero_encoder;
        got.sample_valid    = out_sample_valid;
        got.orientation     = out_orientation;
        got.sample_distance = out_sample_distance;
        got.sweep_end       = out_sweep_end;
        tracker.check_result(got);
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_tick(input logic run, input logic signed [ANGLE_WIDTH-1:0] pos,
                           input logic [STEP_WIDTH-1:0] step,
                           input logic [DIST_WIDTH-1:0] reading);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_run        <= run;
    in_position   <= pos;
    in_step_count <= step;
    in_distance   <= reading;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [SPEED_WIDTH-1:0] speed,
                              input logic [TICKS_WIDTH-1:0] stall,
                              input logic [ANGLE_WIDTH-2:0] step,
                              input logic signed [ANGLE_WIDTH-1:0] stop);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DRIVE_SPEED;
    cfg_data  <= CFG_WIDTH'(speed);
    @(posedge clk);
    cfg_index <= REG_STALL_TICKS;
    cfg_data  <= CFG_WIDTH'(stall);
    @(posedge clk);
    cfg_index <= REG_ANGLE_STEP;
    cfg_data  <= CFG_WIDTH'(step);
    @(posedge clk);
    cfg_index <= REG_STOP_ANGLE;
    cfg_data  <= stop;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_stall = stall;
    cur_astep = step;
  endtask

  // Mostly sweeps: a run of moving ticks, then still ticks (enough to stall while
  // the stall setting is under 16), with some random noise, stop ticks and cut-short holds mixed in.
  task automatic run_items(input int count);
    int          sent;
    int          kind;
    int          holds;
    int unsigned delta;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        send_tick(1'($urandom), ANGLE_WIDTH'($urandom), STEP_WIDTH'($urandom),
                  DIST_WIDTH'($urandom));
        sent++;
      end else if (kind < 12) begin
        send_tick(1'b0, ANGLE_WIDTH'($urandom), STEP_WIDTH'($urandom),
                  DIST_WIDTH'($urandom));
        sent++;
      end else begin
        holds = (cur_stall < 16) ? cur_stall + 1 + $urandom_range(0, 2) : $urandom_range(0, 10);
        if ($urandom_range(9) == 0)
          holds = $urandom_range(0, holds);
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(3))
            0:       delta = $urandom_range(0, cur_astep);
            1:       delta = cur_astep + $urandom_range(0, 2);
            2:       delta = $urandom_range(0, 4 * cur_astep + 16);
            default: delta = $urandom;
          endcase
          if ($urandom_range(1))
            cur_pos = cur_pos + delta[ANGLE_WIDTH-1:0];
          else
            cur_pos = cur_pos - delta[ANGLE_WIDTH-1:0];
          cur_step = cur_step + STEP_WIDTH'($urandom_range(1, 3));
          send_tick(1'b1, cur_pos, cur_step, DIST_WIDTH'($urandom));
          sent++;
        end
        repeat (holds) begin
          send_tick(1'b1, cur_pos, cur_step, DIST_WIDTH'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_valid       <= 1'b0;
    in_run         <= 1'b0;
    in_position    <= '0;
    in_step_count  <= '0;
    in_distance    <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_DRIVE_SPEED;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    cur_stall      = RST_STALL_TICKS;
    cur_astep      = RST_ANGLE_STEP;
    cur_pos        = '0;
    cur_step       = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sweep under reset settings: stop tick, first tick as a move,
    // stall while negative, samples at both position extremes, a small move
    // without a sample, stall while positive with a sweep end, then an
    // immediate second reversal since the idle count is kept.
    send_tick(1'b0, '0, '0, '0);
    send_tick(1'b1, '0, '0, '0);
    repeat (6) send_tick(1'b1, '0, '0, 16'hFFFF);
    send_tick(1'b1, 24'sh7FFFFF, 16'd1, 16'h1234);
    send_tick(1'b1, 24'sh7FFFFF - 24'sd1000, 16'd2, 16'h00FF);
    send_tick(1'b1, 24'sh800000, 16'hFFFF, 16'h0000);
    repeat (6) send_tick(1'b1, 24'sh800000, 16'hFFFF, 16'hA5A5);
    send_tick(1'b1, 24'sh800000, 16'hFFFF, 16'h5A5A);
    drain();

    // Orientation saturating low, then high, with a stall on every tick.
    write_config(8'd255, 16'd0, '0, 24'sh7FFFFF);
    send_tick(1'b1, 24'sh800000, 16'hFFFF, 16'h0001);
    send_tick(1'b1, 24'sh800001, 16'hFFFF, 16'h8000);
    drain();
    write_config(8'd255, 16'd0, '0, 24'sh800000);
    send_tick(1'b1, 24'sh7FFFFF, 16'hFFFF, 16'h7FFF);
    send_tick(1'b1, 24'sh7FFFFF, 16'hFFFF, 16'hFFFE);
    send_tick(1'b0, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       write_config(8'd255, 16'd0, '0, 24'sh800000);
        1:       write_config(8'd1, 16'd2, {(ANGLE_WIDTH-1){1'b1}}, 24'sh7FFFFF);
        2:       write_config(8'd0, 16'hFFFF, 23'd1000, ANGLE_WIDTH'($urandom));
        default: write_config(SPEED_WIDTH'($urandom_range(1, 255)),
                              TICKS_WIDTH'($urandom_range(0, 6)),
                              (ANGLE_WIDTH-1)'($urandom_range(0, 200000)),
                              ANGLE_WIDTH'($urandom));
      endcase
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // Phase 0 holds the output back long enough to fill the block.
      if (phase == 0)
        hold_req = 1'b1;
      if (phase == 5) begin
        run_items(25);
        drain();
        run_items(25);
      end else begin
        run_items(50);
      end
      drain();
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
